FILE: sv/fem_2d_jacobian_cartesian_derivs_assert.svh
// Assertion macros shared by the top module and fjc_front.
// Expects signals named clk and rst in the module that uses them.
`ifndef FEM_2D_JACOBIAN_CARTESIAN_DERIVS_ASSERT_SVH
`define FEM_2D_JACOBIAN_CARTESIAN_DERIVS_ASSERT_SVH

// same-cycle implication, quiet during reset
`define FJC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define FJC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/fjc_pkg.sv
// Shared types and constants for the 2D Jacobian / Cartesian derivative block.
// No dependencies.
`default_nettype none
package fjc_pkg;
  localparam int COORD_W    = 32;
  localparam int SHP_W      = 20;
  localparam int ACC_W      = 56;
  localparam int PROD_W     = 2 * ACC_W + 1;
  localparam int DET_W      = PROD_W + 1;
  localparam int NX_W       = 77;
  localparam int OUT_W      = 32;
  localparam int DETO_W     = 64;
  localparam int IDX_OUT_W  = 4;
  localparam int FIFO_DEPTH = 4;
  localparam int DIG_W      = 14;
  localparam int G_FRAC     = 16;
  localparam int D_FRAC     = 32;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [SHP_W-1:0]   sh;
    logic signed [SHP_W-1:0]   dxi;
    logic signed [SHP_W-1:0]   deta;
    logic                      last;
  } node_t;

  typedef struct packed {
    logic [IDX_OUT_W-1:0]     node_index;
    logic signed [OUT_W-1:0]  deriv_x;
    logic signed [OUT_W-1:0]  deriv_y;
    logic signed [OUT_W-1:0]  gauss_x;
    logic signed [OUT_W-1:0]  gauss_y;
    logic signed [DETO_W-1:0] determinant;
    logic                     valid_res;
    logic                     last_out;
  } res_t;

  typedef enum logic [4:0] {
    BK_ACC, BK_DET1, BK_DET1W, BK_DET2, BK_DET2W, BK_DETF, BK_RD,
    BK_X1, BK_X1W, BK_X2, BK_X2W, BK_XD,
    BK_Y1, BK_Y1W, BK_Y2, BK_Y2W, BK_YD, BK_OUT
  } bk_st_t;

  typedef enum logic [2:0] {
    DV_IDLE, DV_ABS, DV_SUM, DV_CHK, DV_RUN, DV_DONE
  } dv_st_t;
endpackage
`default_nettype wire

FILE: sv/fem_2d_jacobian_cartesian_derivs.sv
// 2D isoparametric element kernel: det(J) and Cartesian shape derivatives.
// Input transactions: push/full, one element node per transaction, last_node
//   closes the element. Result transactions: empty/pop, one per stored node,
//   emitted only after the element's last node, in node order.
// A 4-deep node queue decouples input from the execution back end, so pushes
//   continue while results wait to be popped.
// Throughput: nodes are accumulated one per cycle while the back end is in
//   its accumulate step. Closing an element takes two passes through the
//   shared 56x56 multiplier, four 14-bit digits each. A result needs no
//   multiplier or divider work when det(J) <= 0; otherwise four multiplier
//   passes and two 32-step restoring divisions dominate.
// Reset (synchronous rst) empties the node queue and the result register and clears the accumulators.
// When the receiver stalls, the result register holds, the back end stops in
//   its output step, and the node queue fills and raises full.
// Depends on fjc_pkg, fjc_front, fjc_back and the assertion macro header.
`default_nettype none
`include "fem_2d_jacobian_cartesian_derivs_assert.svh"
module fem_2d_jacobian_cartesian_derivs #(
  parameter int MAX_NODES = 9
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  push,
  output logic                                  full,
  input  logic signed [fjc_pkg::COORD_W-1:0]    node_x,
  input  logic signed [fjc_pkg::COORD_W-1:0]    node_y,
  input  logic signed [fjc_pkg::SHP_W-1:0]      shape_value,
  input  logic signed [fjc_pkg::SHP_W-1:0]      deriv_xi,
  input  logic signed [fjc_pkg::SHP_W-1:0]      deriv_eta,
  input  logic                                  last_node,
  output logic                                  empty,
  input  logic                                  pop,
  output logic [fjc_pkg::IDX_OUT_W-1:0]         node_index,
  output logic signed [fjc_pkg::OUT_W-1:0]      deriv_x,
  output logic signed [fjc_pkg::OUT_W-1:0]      deriv_y,
  output logic signed [fjc_pkg::OUT_W-1:0]      gauss_x,
  output logic signed [fjc_pkg::OUT_W-1:0]      gauss_y,
  output logic signed [fjc_pkg::DETO_W-1:0]     determinant,
  output logic                                  valid_res,
  output logic                                  last_out
);
  import fjc_pkg::*;

  node_t din, head;
  res_t  res, res_r;
  logic  head_vld, head_pop, res_wr, out_vld, out_free;

  always_comb begin
    din.x    = node_x;
    din.y    = node_y;
    din.sh   = shape_value;
    din.dxi  = deriv_xi;
    din.deta = deriv_eta;
    din.last = last_node;
  end

  fjc_front u_front (
    .clk(clk), .rst(rst), .push(push), .din(din), .full(full),
    .head_vld(head_vld), .head(head), .head_pop(head_pop)
  );

  fjc_back #(.MAX_NODES(MAX_NODES)) u_back (
    .clk(clk), .rst(rst), .head_vld(head_vld), .head(head), .head_pop(head_pop),
    .out_free(out_free), .res_wr(res_wr), .res(res)
  );

  // single result register; a pop frees it for a write in the same cycle
  assign out_free = !out_vld || pop;
  assign empty    = !out_vld;

  always_ff @(posedge clk) begin
    if (rst) out_vld <= 1'b0;
    else if (res_wr) out_vld <= 1'b1;
    else if (pop) out_vld <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (res_wr) res_r <= res;
  end

  assign node_index  = res_r.node_index;
  assign deriv_x     = res_r.deriv_x;
  assign deriv_y     = res_r.deriv_y;
  assign gauss_x     = res_r.gauss_x;
  assign gauss_y     = res_r.gauss_y;
  assign determinant = res_r.determinant;
  assign valid_res   = res_r.valid_res;
  assign last_out    = res_r.last_out;

  `FJC_ASSERT_IMP(a_wr_free, res_wr, !out_vld || pop, "result written over waiting one")
  `FJC_ASSERT_NXT(a_wr_shows, res_wr, !empty, "written result not shown")
  `FJC_ASSERT_NXT(a_hold, out_vld && !pop && !res_wr, out_vld && $stable(res_r), "result lost")
endmodule
`default_nettype wire

FILE: sv/fjc_front.sv
// Input side: takes node transactions and queues them for the back end.
// Depends on fjc_pkg and the assertion macro header.
`default_nettype none
`include "fem_2d_jacobian_cartesian_derivs_assert.svh"
module fjc_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  fjc_pkg::node_t din,
  output logic          full,
  output logic          head_vld,
  output fjc_pkg::node_t head,
  input  logic          head_pop
);
  import fjc_pkg::*;
  localparam int PTR_W  = $clog2(FIFO_DEPTH);
  localparam int FILL_W = $clog2(FIFO_DEPTH + 1);

  node_t             mem [FIFO_DEPTH];
  logic [PTR_W-1:0]  wp, rp;
  logic [FILL_W-1:0] fill;
  logic              acc_in;

  assign full     = (fill == FILL_W'(FIFO_DEPTH));
  assign acc_in   = push && !full;
  assign head_vld = (fill != '0);
  assign head     = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      rp   <= '0;
      fill <= '0;
    end else begin
      if (acc_in) wp <= wp + 1'b1;
      if (head_pop) rp <= rp + 1'b1;
      if (acc_in && !head_pop) fill <= fill + 1'b1;
      else if (!acc_in && head_pop) fill <= fill - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_in) mem[wp] <= din;
  end

  `FJC_ASSERT_IMP(a_fill_range, 1'b1, fill <= FILL_W'(FIFO_DEPTH), "queue fill over depth")
  `FJC_ASSERT_IMP(a_no_underflow, head_pop, fill != '0, "pop from empty queue")
  `FJC_ASSERT_NXT(a_fill_up, acc_in && !head_pop, fill == $past(fill) + 1'b1, "fill not bumped")
endmodule
`default_nettype wire

FILE: sv/fjc_mul.sv
// Shared sign-magnitude multiplier, one 14-bit digit of b per cycle.
// Depends on fjc_pkg.
`default_nettype none
module fjc_mul (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [fjc_pkg::ACC_W-1:0]   a,
  input  logic signed [fjc_pkg::ACC_W-1:0]   b,
  output logic                               done,
  output logic signed [fjc_pkg::PROD_W-1:0]  prod
);
  import fjc_pkg::*;
  localparam int NDIG = ACC_W / DIG_W;
  localparam int DC_W = $clog2(NDIG);

  logic [ACC_W-1:0]       ma, mb, abs_a, abs_b;
  logic [2*ACC_W-1:0]     acc;
  logic [ACC_W+DIG_W-1:0] part;
  logic                   neg, busy, fin;
  logic [DC_W-1:0]        dig;

  always_comb begin
    abs_a = a[ACC_W-1] ? ACC_W'(-a) : ACC_W'(a);
    abs_b = b[ACC_W-1] ? ACC_W'(-b) : ACC_W'(b);
    part  = (ACC_W+DIG_W)'(ma) * (ACC_W+DIG_W)'(mb[ACC_W-1 -: DIG_W]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      dig  <= '0;
    end else begin
      done <= fin;
      fin  <= !start && busy && (dig == DC_W'(NDIG - 1));
      if (start) begin
        busy <= 1'b1;
        dig  <= '0;
      end else if (busy) begin
        if (dig == DC_W'(NDIG - 1)) begin
          busy <= 1'b0;
        end
        dig <= dig + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ma  <= abs_a;
      mb  <= abs_b;
      neg <= a[ACC_W-1] ^ b[ACC_W-1];
      acc <= '0;
    end else if (busy) begin
      acc <= (acc << DIG_W) + (2*ACC_W)'(part);
      mb  <= mb << DIG_W;
    end
    if (fin) prod <= neg ? -$signed({1'b0, acc}) : $signed({1'b0, acc});
  end
endmodule
`default_nettype wire

FILE: sv/fjc_div.sv
// Rounded, saturated quotient num * 2^32 / den, restoring, one bit per cycle.
// Depends on fjc_pkg.
`default_nettype none
module fjc_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [fjc_pkg::NX_W-1:0]   num,
  input  logic [fjc_pkg::DET_W-2:0]         den,
  output logic                              done,
  output logic signed [fjc_pkg::OUT_W-1:0]  quot
);
  import fjc_pkg::*;
  localparam int MAG_W = NX_W - 1;
  localparam int SUM_W = DET_W;
  localparam int REM_W = SUM_W + 1;
  localparam int CN_W  = $clog2(OUT_W);

  dv_st_t             st, st_next;
  logic signed [NX_W-1:0] numr;
  logic [DET_W-2:0]   denr;
  logic [MAG_W-1:0]   mag;
  logic               neg, ovf;
  logic [REM_W-1:0]   rem, dd, t;
  logic [OUT_W-1:0]   low, quo;
  logic [CN_W-1:0]    cnt;
  logic [SUM_W-1:0]   nsum;
  logic [OUT_W:0]     lim, magq, resv;

  always_comb begin
    dd   = {1'b0, denr, 1'b0};
    nsum = SUM_W'({mag, {(OUT_W+1){1'b0}}}) + SUM_W'(denr);
    t    = {rem[REM_W-2:0], low[OUT_W-1]};
    lim  = {1'b0, neg, {(OUT_W-1){!neg}}};
    magq = (ovf || ({1'b0, quo} > lim)) ? lim : {1'b0, quo};
    resv = neg ? -magq : magq;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= DV_IDLE;
      done <= 1'b0;
    end else begin
      st   <= st_next;
      done <= (st == DV_DONE);
    end
  end

  always_comb begin
    st_next = st;
    case (st)
      DV_IDLE: if (start) st_next = DV_ABS;
      DV_ABS:  st_next = DV_SUM;
      DV_SUM:  st_next = DV_CHK;
      DV_CHK:  st_next = DV_RUN;
      DV_RUN:  if (cnt == CN_W'(OUT_W - 1)) st_next = DV_DONE;
      DV_DONE: st_next = DV_IDLE;
      default: st_next = DV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (st)
      DV_IDLE: if (start) begin
        numr <= num;
        denr <= den;
      end
      DV_ABS: begin
        mag <= numr[NX_W-1] ? MAG_W'(-numr) : MAG_W'(numr);
        neg <= numr[NX_W-1];
      end
      DV_SUM: begin
        rem <= REM_W'(nsum >> OUT_W);
        low <= nsum[OUT_W-1:0];
      end
      DV_CHK: begin
        ovf <= (rem >= dd);
        cnt <= '0;
        quo <= '0;
      end
      DV_RUN: begin
        if (t >= dd) begin
          rem <= t - dd;
          quo <= {quo[OUT_W-2:0], 1'b1};
        end else begin
          rem <= t;
          quo <= {quo[OUT_W-2:0], 1'b0};
        end
        low <= low << 1;
        cnt <= cnt + 1'b1;
      end
      DV_DONE: quot <= resv[OUT_W-1:0];
      default: ;
    endcase
  end
endmodule
`default_nettype wire

FILE: sv/fjc_back.sv
// Execution side: accumulates nodes, forms det(J), then per-node derivatives.
// Depends on fjc_pkg, fjc_mul and fjc_div.
`default_nettype none
module fjc_back #(
  parameter int MAX_NODES = 9
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_vld,
  input  fjc_pkg::node_t head,
  output logic           head_pop,
  input  logic           out_free,
  output logic           res_wr,
  output fjc_pkg::res_t  res
);
  import fjc_pkg::*;
  localparam int CNT_W = $clog2(MAX_NODES + 1);
  localparam int IDX_W = $clog2(MAX_NODES);
  localparam int PN_W  = COORD_W + SHP_W;

  bk_st_t st, st_next;

  logic signed [ACC_W-1:0]  jac [4];
  logic signed [ACC_W-1:0]  gacc [2];
  logic [CNT_W-1:0]         cnt, n;
  logic signed [SHP_W-1:0]  st_a [MAX_NODES];
  logic signed [SHP_W-1:0]  st_b [MAX_NODES];
  logic signed [SHP_W-1:0]  ra, rb;
  logic signed [PROD_W-1:0] p_hold, prod;
  logic signed [DET_W-1:0]  det;
  logic                     valid;
  logic signed [DETO_W-1:0] det_out;
  logic signed [OUT_W-1:0]  gx, gy, cx, cy, quot;
  logic signed [PN_W-1:0]   pgx, pgy, pj0, pj1, pj2, pj3;
  logic                     take, is_last;
  logic                     mul_start, mul_done, div_start, div_done;
  logic signed [ACC_W-1:0]  mul_a, mul_b;
  logic signed [NX_W-1:0]   div_num;

  function automatic logic signed [OUT_W-1:0] sat_g(input logic signed [ACC_W-1:0] g);
    logic signed [ACC_W:0] r;
    r = {g[ACC_W-1], g} + (ACC_W+1)'(1 << (G_FRAC - 1));
    if ((&r[ACC_W:G_FRAC+OUT_W-1]) || !(|r[ACC_W:G_FRAC+OUT_W-1]))
      return r[G_FRAC+OUT_W-1:G_FRAC];
    return r[ACC_W] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
  endfunction

  function automatic logic signed [DETO_W-1:0] sat_d(input logic signed [DET_W-1:0] d);
    logic signed [DET_W:0] r;
    r = {d[DET_W-1], d} + {{(DET_W-D_FRAC+1){1'b0}}, 1'b1, {(D_FRAC-1){1'b0}}};
    if ((&r[DET_W:D_FRAC+DETO_W-1]) || !(|r[DET_W:D_FRAC+DETO_W-1]))
      return r[D_FRAC+DETO_W-1:D_FRAC];
    return r[DET_W] ? {1'b1, {(DETO_W-1){1'b0}}} : {1'b0, {(DETO_W-1){1'b1}}};
  endfunction

  always_comb begin
    pgx     = head.x * head.sh;
    pgy     = head.y * head.sh;
    pj0     = head.dxi * head.x;
    pj1     = head.dxi * head.y;
    pj2     = head.deta * head.x;
    pj3     = head.deta * head.y;
    take    = (st == BK_ACC) && head_vld && (cnt < CNT_W'(MAX_NODES));
    is_last = ((n + 1'b1) == cnt);
    div_num = NX_W'(p_hold - prod);
  end

  fjc_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .prod(prod)
  );

  fjc_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(det[DET_W-2:0]),
    .done(div_done), .quot(quot)
  );

  always_ff @(posedge clk) begin
    if (rst) st <= BK_ACC;
    else st <= st_next;
  end

  always_comb begin
    st_next   = st;
    head_pop  = 1'b0;
    mul_start = 1'b0;
    mul_a     = jac[0];
    mul_b     = jac[3];
    div_start = 1'b0;
    res_wr    = 1'b0;
    case (st)
      BK_ACC: if (head_vld) begin
        head_pop = 1'b1;
        if (head.last) st_next = BK_DET1;
      end
      BK_DET1: begin
        mul_start = 1'b1;
        st_next   = BK_DET1W;
      end
      BK_DET1W: if (mul_done) st_next = BK_DET2;
      BK_DET2: begin
        mul_start = 1'b1;
        mul_a     = jac[1];
        mul_b     = jac[2];
        st_next   = BK_DET2W;
      end
      BK_DET2W: if (mul_done) st_next = BK_DETF;
      BK_DETF: st_next = BK_RD;
      BK_RD: st_next = valid ? BK_X1 : BK_OUT;
      BK_X1: begin
        mul_start = 1'b1;
        mul_a     = jac[3];
        mul_b     = ACC_W'(ra);
        st_next   = BK_X1W;
      end
      BK_X1W: if (mul_done) st_next = BK_X2;
      BK_X2: begin
        mul_start = 1'b1;
        mul_a     = jac[1];
        mul_b     = ACC_W'(rb);
        st_next   = BK_X2W;
      end
      BK_X2W: if (mul_done) begin
        div_start = 1'b1;
        st_next   = BK_XD;
      end
      BK_XD: if (div_done) st_next = BK_Y1;
      BK_Y1: begin
        mul_start = 1'b1;
        mul_a     = jac[0];
        mul_b     = ACC_W'(rb);
        st_next   = BK_Y1W;
      end
      BK_Y1W: if (mul_done) st_next = BK_Y2;
      BK_Y2: begin
        mul_start = 1'b1;
        mul_a     = jac[2];
        mul_b     = ACC_W'(ra);
        st_next   = BK_Y2W;
      end
      BK_Y2W: if (mul_done) begin
        div_start = 1'b1;
        st_next   = BK_YD;
      end
      BK_YD: if (div_done) st_next = BK_OUT;
      BK_OUT: if (out_free) begin
        res_wr  = 1'b1;
        st_next = is_last ? BK_ACC : BK_RD;
      end
      default: st_next = BK_ACC;
    endcase
  end

  // element accumulators, cleared at reset and after the last result
  always_ff @(posedge clk) begin
    if (rst || (res_wr && is_last)) begin
      cnt     <= '0;
      jac[0]  <= '0;
      jac[1]  <= '0;
      jac[2]  <= '0;
      jac[3]  <= '0;
      gacc[0] <= '0;
      gacc[1] <= '0;
    end else if (take) begin
      cnt     <= cnt + 1'b1;
      gacc[0] <= gacc[0] + ACC_W'(pgx);
      gacc[1] <= gacc[1] + ACC_W'(pgy);
      jac[0]  <= jac[0] + ACC_W'(pj0);
      jac[1]  <= jac[1] + ACC_W'(pj1);
      jac[2]  <= jac[2] + ACC_W'(pj2);
      jac[3]  <= jac[3] + ACC_W'(pj3);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      st_a[cnt[IDX_W-1:0]] <= head.dxi;
      st_b[cnt[IDX_W-1:0]] <= head.deta;
    end
    case (st)
      BK_DET1W, BK_X1W, BK_Y1W: if (mul_done) p_hold <= prod;
      BK_DET2W: if (mul_done) det <= DET_W'(p_hold) - DET_W'(prod);
      BK_DETF: begin
        valid   <= !det[DET_W-1] && (|det);
        det_out <= sat_d(det);
        gx      <= sat_g(gacc[0]);
        gy      <= sat_g(gacc[1]);
        n       <= '0;
      end
      BK_RD: begin
        ra <= st_a[n[IDX_W-1:0]];
        rb <= st_b[n[IDX_W-1:0]];
        cx <= '0;
        cy <= '0;
      end
      BK_XD: if (div_done) cx <= quot;
      BK_YD: if (div_done) cy <= quot;
      BK_OUT: if (res_wr && !is_last) n <= n + 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    res.node_index  = IDX_OUT_W'(n);
    res.deriv_x     = cx;
    res.deriv_y     = cy;
    res.gauss_x     = gx;
    res.gauss_y     = gy;
    res.determinant = det_out;
    res.valid_res   = valid;
    res.last_out    = is_last;
  end
endmodule
`default_nettype wire

FILE: test/tb_top.sv
// Testbench for fem_2d_jacobian_cartesian_derivs: element nodes in, one checked
// transaction per stored node out. Depends on fjc_pkg and the block's RTL.
`timescale 1ns / 1ps
module tb_top;
  import fjc_pkg::*;

  localparam int NODE_CAP   = 9;      // MAX_NODES of the block
  localparam int STALL_LIM  = 6000;   // idle cycles before the watchdog trips
  localparam int DRAIN_WAIT = 300;    // quiet cycles after the last result
  localparam int HOLD_LEN   = 900;    // long receiver hold-off

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty;
  logic signed [31:0] node_x = '0, node_y = '0;
  logic signed [19:0] shape_value = '0, deriv_xi = '0, deriv_eta = '0;
  logic last_node = 1'b0;
  logic [3:0] node_index;
  logic signed [31:0] deriv_x, deriv_y, gauss_x, gauss_y;
  logic signed [63:0] determinant;
  logic valid_res, last_out;

  fem_2d_jacobian_cartesian_derivs dut (.*);

  initial forever #2 clk = ~clk;

  // ---- element predictor state ----
  logic signed [127:0] jac_sum [4];   // J entries, exact Q.32
  logic signed [127:0] gpt_sum [2];   // sum N*x, N*y, exact Q.32
  logic signed [19:0]  held_dxi [NODE_CAP];
  logic signed [19:0]  held_deta [NODE_CAP];
  int                  held_cnt = 0;

  res_t expected_res [$];
  int   errors = 0;
  int   send_idle = 0;   // percent of sender cycles with push low
  int   recv_idle = 0;   // percent of cycles with pop low
  bit   hold_start = 0;
  int   hold_left = 0;
  int   quiet_cycles = 0;

  function automatic logic signed [31:0] clamp32(logic signed [127:0] v);
    if (v > 128'sd2147483647) return 32'sh7fffffff;
    if (v < -128'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [63:0] clamp64(logic signed [127:0] v);
    if (v > 128'sd9223372036854775807) return {1'b0, {63{1'b1}}};
    if (v < -128'sd9223372036854775807 - 1) return {1'b1, {63{1'b0}}};
    return v[63:0];
  endfunction

  // round(num * 2^32 / det), half away from zero, saturated; det > 0
  function automatic logic signed [31:0] cart_quot(logic signed [127:0] num,
                                                   logic signed [127:0] det);
    logic [191:0] mag, q, dv;
    logic [191:0] lim;
    bit neg;
    neg = num < 0;
    mag = neg ? 192'(-num) : 192'(num);
    dv = 192'(det);
    q = ((mag << 33) + dv) / (dv << 1);
    lim = neg ? 192'(64'h80000000) : 192'(64'h7fffffff);
    if (q > lim) q = lim;
    return neg ? -q[31:0] : q[31:0];
  endfunction

  function automatic void clear_element();
    foreach (jac_sum[i]) jac_sum[i] = '0;
    foreach (gpt_sum[i]) gpt_sum[i] = '0;
    held_cnt = 0;
  endfunction

  // accumulate one accepted node; on the last node queue its element's results
  function automatic void predict_node(logic signed [31:0] x, logic signed [31:0] y,
                                       logic signed [19:0] sh, logic signed [19:0] dxi,
                                       logic signed [19:0] deta, logic last);
    logic signed [127:0] det, nx, ny;
    logic signed [63:0] det_o;
    logic signed [31:0] gx, gy;
    bit ok;
    res_t r;
    if (held_cnt < NODE_CAP) begin
      gpt_sum[0] += x * sh;
      gpt_sum[1] += y * sh;
      jac_sum[0] += dxi * x;
      jac_sum[1] += dxi * y;
      jac_sum[2] += deta * x;
      jac_sum[3] += deta * y;
      held_dxi[held_cnt] = dxi;
      held_deta[held_cnt] = deta;
      held_cnt++;
    end
    if (!last) return;
    det = jac_sum[0] * jac_sum[3] - jac_sum[1] * jac_sum[2];
    ok = det > 0;
    det_o = clamp64((det + (128'sd1 <<< 31)) >>> 32);
    gx = clamp32((gpt_sum[0] + 128'sd32768) >>> 16);
    gy = clamp32((gpt_sum[1] + 128'sd32768) >>> 16);
    for (int n = 0; n < held_cnt; n++) begin
      r = '0;
      r.node_index = n[3:0];
      if (ok) begin
        nx = jac_sum[3] * held_dxi[n] - jac_sum[1] * held_deta[n];
        ny = jac_sum[0] * held_deta[n] - jac_sum[2] * held_dxi[n];
        r.deriv_x = cart_quot(nx, det);
        r.deriv_y = cart_quot(ny, det);
      end
      r.gauss_x = gx;
      r.gauss_y = gy;
      r.determinant = det_o;
      r.valid_res = ok;
      r.last_out = (n + 1 == held_cnt);
      expected_res.push_back(r);
    end
    clear_element();
  endfunction

  // one input transaction; push stays high for a following item
  task automatic send_node(logic [31:0] x, logic [31:0] y, logic [19:0] sh,
                           logic [19:0] dxi, logic [19:0] deta, logic last);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    node_x <= x; node_y <= y; shape_value <= sh;
    deriv_xi <= dxi; deriv_eta <= deta; last_node <= last;
    push <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_node(x, y, sh, dxi, deta, last);
  endtask

  // element of n nodes; wild = any bit pattern, else moderate geometry
  task automatic send_element(int n, bit wild);
    logic [31:0] x, y;
    for (int i = 0; i < n; i++) begin
      if (wild) begin
        x = $urandom; y = $urandom;
      end else begin
        x = 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
        y = 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
      end
      send_node(x, y, 20'($urandom), 20'($urandom), 20'($urandom), i == n - 1);
    end
  endtask

  function automatic int pick_size();
    int k;
    k = $urandom_range(99);
    if (k < 8) return $urandom_range(1, 2);
    if (k < 18) return $urandom_range(10, 12);  // overflow of the node store
    return $urandom_range(3, 9);
  endfunction

  // receiver: random pop, or a counted hold-off
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_start) begin
      hold_start = 0;
      hold_left = HOLD_LEN;
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle);
    end
  end

  // result checker and watchdog
  always @(posedge clk) begin
    res_t e;
    if (!rst) begin
      if ((push && !full) || (pop && !empty)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIM) begin
        $display("simulation failed");
        $finish;
      end
      if (pop && !empty) begin
        if (expected_res.size() == 0) begin
          $error("unexpected result transaction, node_index %0d", node_index);
          errors++;
        end else begin
          e = expected_res.pop_front();
          if (node_index !== e.node_index) begin
            $error("node_index exp %0d got %0d", e.node_index, node_index); errors++;
          end
          if (deriv_x !== e.deriv_x) begin
            $error("deriv_x exp %0d got %0d", e.deriv_x, deriv_x); errors++;
          end
          if (deriv_y !== e.deriv_y) begin
            $error("deriv_y exp %0d got %0d", e.deriv_y, deriv_y); errors++;
          end
          if (gauss_x !== e.gauss_x) begin
            $error("gauss_x exp %0d got %0d", e.gauss_x, gauss_x); errors++;
          end
          if (gauss_y !== e.gauss_y) begin
            $error("gauss_y exp %0d got %0d", e.gauss_y, gauss_y); errors++;
          end
          if (determinant !== e.determinant) begin
            $error("determinant exp %0d got %0d", e.determinant, determinant); errors++;
          end
          if (valid_res !== e.valid_res) begin
            $error("valid_res exp %0d got %0d", e.valid_res, valid_res); errors++;
          end
          if (last_out !== e.last_out) begin
            $error("last_out exp %0d got %0d", e.last_out, last_out); errors++;
          end
        end
      end
    end
  end

  // unit square, both windings, degenerate, extremes, tiny determinant, overflow, lone node
  task automatic test_directed();
    localparam logic [31:0] ONE = 32'h0001_0000;
    localparam logic [19:0] Q = 20'h04000, NQ = -20'sh04000;
    send_node(0, 0, Q, NQ, NQ, 0);
    send_node(ONE, 0, Q, Q, NQ, 0);
    send_node(ONE, ONE, Q, Q, Q, 0);
    send_node(0, ONE, Q, NQ, Q, 1);
    // mirrored: negative determinant
    send_node(0, 0, Q, NQ, NQ, 0);
    send_node(0, ONE, Q, Q, NQ, 0);
    send_node(ONE, ONE, Q, Q, Q, 0);
    send_node(ONE, 0, Q, NQ, Q, 1);
    // zero determinant
    send_node(0, 0, 0, 0, 0, 1);
    // field extremes, saturating outputs
    send_node(32'h7fffffff, 32'h80000000, 20'h7ffff, 20'h7ffff, 20'h80000, 0);
    send_node(32'h80000000, 32'h7fffffff, 20'h80000, 20'h80000, 20'h7ffff, 1);
    send_node(32'h7fffffff, 32'h7fffffff, 20'h7ffff, 20'h7ffff, 20'h00001, 0);
    send_node(32'h80000000, 32'h00000000, 20'h80000, 20'h00001, 20'h7ffff, 1);
    // tiny positive determinant, huge derivatives
    send_node(32'h00000001, 0, 20'h7ffff, 20'h7ffff, 0, 0);
    send_node(0, 32'h00000001, 20'h80000, 0, 20'h7ffff, 1);
    // more nodes than the store holds
    send_element(11, 0);
    // single node
    send_node(ONE, 32'hffff0000, 20'h10000, 20'h10000, 20'h10000, 1);
  endtask

  task automatic test_random(int items, int s_idle, int r_idle);
    int sent, n;
    send_idle = s_idle;
    recv_idle = r_idle;
    sent = 0;
    while (sent < items) begin
      n = pick_size();
      send_element(n, $urandom_range(9) < 2);
      sent += n;
    end
  endtask

  // receiver holds off while nodes keep coming, filling the node queue
  task automatic test_backpressure();
    send_idle = 0;
    recv_idle = 0;
    hold_start = 1;
    repeat (5) send_element($urandom_range(3, 9), 0);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    clear_element();
    test_directed();
    test_random(85, 37, 66);
    test_random(85, 66, 37);
    test_backpressure();
    test_random(70, 0, 0);
    push <= 1'b0;
    while (expected_res.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0 && expected_res.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

FILE: fem_2d_jacobian_cartesian_derivs.f
+incdir+sv
sv/fjc_pkg.sv
sv/fjc_front.sv
sv/fjc_mul.sv
sv/fjc_div.sv
sv/fjc_back.sv
sv/fem_2d_jacobian_cartesian_derivs.sv
test/tb_top.sv
